// ----- design/sbwm_pkg.sv -----
// Shared types and constants of the SSIM box window metric unit.
package sbwm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_WINDOW = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int RRW        = $clog2(MAX_WINDOW);
	localparam int RING_DEPTH = MAX_WIDTH * MAX_WINDOW;
	localparam int LW         = 16;
	localparam int CW         = 21;
	localparam int TW         = 48;
	localparam int FW         = 52;

	localparam logic [18:0] STAB_K1   = 19'd426148;
	localparam logic [21:0] STAB_K2   = 22'd3835319;
	localparam logic [CW-1:0] COUNT_CAP = 21'd1048576;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH   = 2'd0,
		CFG_FRAME_HEIGHT  = 2'd1,
		CFG_WINDOW_SIZE   = 2'd2,
		CFG_WINDOW_STRIDE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [10:0] frame_width;
		logic [15:0] frame_height;
		logic [4:0]  window_size;
		logic [10:0] window_stride;
	} cfg_t;

	typedef struct packed {
		logic [LW-1:0]  la;
		logic [LW-1:0]  lb;
		logic [XW-1:0]  x;
		logic [RRW-1:0] ring_row;
		logic           first_row;
		logic           full;
		logic           fire;
		logic           last;
		logic           ok;
		logic           inv;
	} item_t;

	typedef struct packed {
		logic [35:0] cab;
		logic [35:0] sbb;
		logic [35:0] saa;
		logic [19:0] sb;
		logic [19:0] sa;
	} col_t;

endpackage

// ----- design/ssim_box_window_metric_unit.sv -----
// Top level of the SSIM box window metric unit.
//
// channel  direction  handshake               payload
// s_axis   in         tvalid/tready           pixel pair word
// m_axis   out        tvalid/tready           frame result word
// cfg      in         cfg_we                  register index and data
//
// Pixel words enter a four word queue at one per cycle while it is not full;
// the back part then reads the ring and updates the column sums per pixel
// (skipped with invalid window settings), sums the window for a pixel that
// closes one and, at frame end, runs a 48 step bit-serial mean divide. The
// back sequencer sets the rate. Reset is asynchronous; the result register
// lets the next frame proceed while a result waits on m_axis_tready.
module ssim_box_window_metric_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// a_red, a_green, a_blue, b_red, b_green, b_blue
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// ssim_mean, window_count, zero padding
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	sbwm_pkg::cfg_t  cfg_q;
	sbwm_pkg::item_t push_item, pop_item;
	logic push, pop, full, empty;
	logic [15:0] mean;
	logic [20:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= 11'd1024;
			cfg_q.frame_height  <= 16'd1024;
			cfg_q.window_size   <= 5'd8;
			cfg_q.window_stride <= 11'd4;
		end else if (cfg_we) begin
			unique case (sbwm_pkg::cfg_idx_t'(cfg_index))
				sbwm_pkg::CFG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_wdata[10:0];
				sbwm_pkg::CFG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_wdata;
				sbwm_pkg::CFG_WINDOW_SIZE:   cfg_q.window_size   <= cfg_wdata[4:0];
				sbwm_pkg::CFG_WINDOW_STRIDE: cfg_q.window_stride <= cfg_wdata[10:0];
				default: begin
				end
			endcase
		end
	end

	sbwm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.restart  (cfg_we),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.push     (push),
		.item     (push_item),
		.full     (full)
	);

	sbwm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_item),
		.full   (full),
		.pop    (pop),
		.dout   (pop_item),
		.empty  (empty)
	);

	sbwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_we),
		.win       (cfg_q.window_size),
		.empty     (empty),
		.pop       (pop),
		.item      (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_mean  (mean),
		.out_count (count)
	);

	assign m_axis_tdata = {3'b0, count, mean};

endmodule

// ----- design/sbwm_ram.sv -----
// Generic single write port RAM with registered read.
module sbwm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- design/sbwm_fifo.sv -----
// Short word queue between the front and back parts.
module sbwm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sbwm_pkg::item_t din,
	output logic           full,
	input  logic           pop,
	output sbwm_pkg::item_t dout,
	output logic           empty
);

	localparam int PW = $clog2(sbwm_pkg::FIFO_DEPTH);

	sbwm_pkg::item_t ent_q [sbwm_pkg::FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW+1)'(sbwm_pkg::FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
		end
	end

endmodule

// ----- design/sbwm_front.sv -----
// Front part: takes pixel words, forms luma and classifies each position.
module sbwm_front (
	input  logic             clk,
	input  logic             arst_n,
	input  sbwm_pkg::cfg_t   cfg,
	input  logic             restart,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [47:0]      in_data,
	output logic             push,
	output sbwm_pkg::item_t  item,
	input  logic             full
);

	logic [sbwm_pkg::XW-1:0]  x_q;
	logic [15:0]              y_q;
	logic [sbwm_pkg::RRW-1:0] rr_q;
	logic [10:0]              cph_q, rph_q;
	logic [10:0]              x1;
	logic [16:0]              y1;
	logic [4:0]               win;
	logic [10:0]              st;
	logic                     inv, ok, colfire, rowfire, end_col, end_row;

	function automatic logic [15:0] to_luma(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [23:0] s;
		s = 24'd19595 * 24'(r) + 24'd38470 * 24'(g) + 24'd7471 * 24'(b);
		return s[23:8];
	endfunction

	assign win     = cfg.window_size;
	assign st      = cfg.window_stride;
	assign x1      = {1'b0, x_q} + 11'd1;
	assign y1      = {1'b0, y_q} + 17'd1;
	assign inv     = cfg.frame_width == '0 || cfg.frame_width > 11'(sbwm_pkg::MAX_WIDTH)
		|| cfg.frame_height == '0;
	assign ok      = win >= 5'd2 && 32'(win) <= sbwm_pkg::MAX_WINDOW && st != '0
		&& {6'b0, win} <= cfg.frame_width && {11'b0, win} <= cfg.frame_height;
	assign colfire = x1 >= {6'b0, win} && cph_q == '0;
	assign rowfire = y1 >= {12'b0, win} && rph_q == '0;
	assign end_col = x1 == cfg.frame_width;
	assign end_row = y1 == {1'b0, cfg.frame_height};

	assign in_ready = !full;
	assign push     = in_valid && !full;

	always_comb begin
		item.la        = to_luma(in_data[7:0], in_data[15:8], in_data[23:16]);
		item.lb        = to_luma(in_data[31:24], in_data[39:32], in_data[47:40]);
		item.x         = x_q;
		item.ring_row  = rr_q;
		item.first_row = y_q == '0;
		item.full      = y_q >= {11'b0, win};
		item.fire      = ok && colfire && rowfire;
		item.last      = end_col && end_row;
		item.ok        = ok;
		item.inv       = inv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			rr_q  <= '0;
			cph_q <= '0;
			rph_q <= '0;
		end else if (restart || (push && inv)) begin
			x_q   <= '0;
			y_q   <= '0;
			rr_q  <= '0;
			cph_q <= '0;
			rph_q <= '0;
		end else if (push) begin
			if (end_col) begin
				x_q   <= '0;
				cph_q <= '0;
				if (end_row) begin
					y_q   <= '0;
					rr_q  <= '0;
					rph_q <= '0;
				end else begin
					y_q  <= y1[15:0];
					rr_q <= ({1'b0, rr_q} + 5'd1 == win) ? '0 : rr_q + 1'b1;
					if (y1 >= {12'b0, win}) begin
						rph_q <= (rph_q + 11'd1 == st) ? '0 : rph_q + 11'd1;
					end
				end
			end else begin
				x_q <= x1[sbwm_pkg::XW-1:0];
				if (x1 >= {6'b0, win}) begin
					cph_q <= (cph_q + 11'd1 == st) ? '0 : cph_q + 11'd1;
				end
			end
		end
	end

endmodule

// ----- design/sbwm_back.sv -----
// Back part: column sums, window SSIM, frame mean and the result register.
module sbwm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            restart,
	input  logic [4:0]      win,
	input  logic            empty,
	output logic            pop,
	input  sbwm_pkg::item_t item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [15:0]     out_mean,
	output logic [20:0]     out_count
);

	typedef enum logic [14:0] {
		S_IDLE = 15'b000000000000001,
		S_RD   = 15'b000000000000010,
		S_MUL  = 15'b000000000000100,
		S_UPD  = 15'b000000000001000,
		S_SUM  = 15'b000000000010000,
		S_P1   = 15'b000000000100000,
		S_P2   = 15'b000000001000000,
		S_LD   = 15'b000000010000000,
		S_DV   = 15'b000000100000000,
		S_MG   = 15'b000001000000000,
		S_AC   = 15'b000010000000000,
		S_FD   = 15'b000100000000000,
		S_FDS  = 15'b001000000000000,
		S_FM   = 15'b010000000000000,
		S_EMIT = 15'b100000000000000
	} state_t;

	localparam int FW = sbwm_pkg::FW;
	localparam int XW = sbwm_pkg::XW;

	state_t state_q;
	sbwm_pkg::item_t it_q;

	logic [31:0] ring_rd;
	sbwm_pkg::col_t col_rd, col_new;
	logic [XW-1:0] col_raddr, base;
	logic [15:0] oa, ob;

	logic [31:0] na_sq_q, nb_sq_q, nab_q, oa_sq_q, ob_sq_q, oab_q;
	logic [23:0] sa_q, sb_q;
	logic [39:0] saa_q, sbb_q, sab_q;
	logic [4:0]  k_q;
	logic [8:0]  n_q;
	logic [16:0] nn_q;
	logic [47:0] p_ab_q, p_aa_q, p_bb_q;
	logic [35:0] kn1_q;
	logic [38:0] kn2_q;
	logic [48:0] nsab_q;
	logic [49:0] nsq_q;
	logic [FW-1:0] f1_q, f3_q, f4_q, pos_q, neg_q;
	logic [FW-1:0] num1_q, den1_q, num2_q, den2_q, t1, t2;
	logic [14:0] q1_q, q2_q;
	logic sat1_q, sat2_q, negf_q;
	logic [5:0] it6_q;
	logic [15:0] r1, r2;
	logic [31:0] prod;
	logic [16:0] mag_q, ssim;
	logic signed [sbwm_pkg::TW-1:0] total_q;
	logic [sbwm_pkg::CW-1:0] count_q;
	logic [sbwm_pkg::TW-1:0] dvd_q;
	logic [21:0] rem_q, rem_n;
	logic tneg_q;
	logic [15:0] res_mean_q;
	logic out_free;

	assign pop      = state_q == S_IDLE && !empty;
	assign out_free = !out_valid || out_ready;
	assign oa       = ring_rd[15:0];
	assign ob       = ring_rd[31:16];
	assign base     = XW'({1'b0, it_q.x} + 11'd1 - 11'(win));
	assign col_raddr = (state_q == S_SUM) ? base + XW'(k_q) : it_q.x;

	sbwm_ram #(.WIDTH(32), .DEPTH(sbwm_pkg::RING_DEPTH)) u_ring (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr ({it_q.ring_row, it_q.x}),
		.wdata ({it_q.lb, it_q.la}),
		.raddr ({it_q.ring_row, it_q.x}),
		.rdata (ring_rd)
	);

	sbwm_ram #(.WIDTH($bits(sbwm_pkg::col_t)), .DEPTH(sbwm_pkg::MAX_WIDTH)) u_col (
		.clk   (clk),
		.we    (state_q == S_UPD),
		.waddr (it_q.x),
		.wdata (col_new),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	always_comb begin
		if (it_q.first_row) begin
			col_new.sa  = 20'(it_q.la);
			col_new.sb  = 20'(it_q.lb);
			col_new.saa = 36'(na_sq_q);
			col_new.sbb = 36'(nb_sq_q);
			col_new.cab = 36'(nab_q);
		end else begin
			col_new.sa  = col_rd.sa + 20'(it_q.la) - (it_q.full ? 20'(oa) : 20'd0);
			col_new.sb  = col_rd.sb + 20'(it_q.lb) - (it_q.full ? 20'(ob) : 20'd0);
			col_new.saa = col_rd.saa + 36'(na_sq_q) - (it_q.full ? 36'(oa_sq_q) : 36'd0);
			col_new.sbb = col_rd.sbb + 36'(nb_sq_q) - (it_q.full ? 36'(ob_sq_q) : 36'd0);
			col_new.cab = col_rd.cab + 36'(nab_q) - (it_q.full ? 36'(oab_q) : 36'd0);
		end
	end

	assign t1    = {num1_q[FW-2:0], 1'b0};
	assign t2    = {num2_q[FW-2:0], 1'b0};
	assign r1    = sat1_q ? 16'h8000 : {1'b0, q1_q};
	assign r2    = sat2_q ? 16'h8000 : {1'b0, q2_q};
	assign prod  = r1 * r2;
	assign ssim  = negf_q ? -mag_q : ((mag_q > 17'd32767) ? 17'd32767 : mag_q);
	assign rem_n = {rem_q[20:0], dvd_q[sbwm_pkg::TW-1]};

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					it_q <= item;
				end
			end
			S_MUL: begin
				na_sq_q <= it_q.la * it_q.la;
				nb_sq_q <= it_q.lb * it_q.lb;
				nab_q   <= it_q.la * it_q.lb;
				oa_sq_q <= oa * oa;
				ob_sq_q <= ob * ob;
				oab_q   <= oa * ob;
			end
			S_UPD: begin
				sa_q  <= '0;
				sb_q  <= '0;
				saa_q <= '0;
				sbb_q <= '0;
				sab_q <= '0;
			end
			S_SUM: begin
				n_q  <= 9'(win) * 9'(win);
				nn_q <= 17'(n_q) * 17'(n_q);
				if (k_q != '0) begin
					sa_q  <= sa_q + 24'(col_rd.sa);
					sb_q  <= sb_q + 24'(col_rd.sb);
					saa_q <= saa_q + 40'(col_rd.saa);
					sbb_q <= sbb_q + 40'(col_rd.sbb);
					sab_q <= sab_q + 40'(col_rd.cab);
				end
			end
			S_P1: begin
				p_ab_q <= sa_q * sb_q;
				p_aa_q <= sa_q * sa_q;
				p_bb_q <= sb_q * sb_q;
				kn1_q  <= 36'(sbwm_pkg::STAB_K1) * 36'(nn_q);
				kn2_q  <= 39'(sbwm_pkg::STAB_K2) * 39'(nn_q);
				nsab_q <= 49'(n_q) * 49'(sab_q);
				nsq_q  <= 50'(n_q) * ({10'b0, saa_q} + {10'b0, sbb_q});
			end
			S_P2: begin
				f1_q  <= {3'b0, p_ab_q, 1'b0} + FW'(kn1_q);
				f3_q  <= FW'(p_aa_q) + FW'(p_bb_q) + FW'(kn1_q);
				pos_q <= {2'b0, nsab_q, 1'b0} + FW'(kn2_q);
				neg_q <= {3'b0, p_ab_q, 1'b0};
				f4_q  <= FW'(nsq_q) - FW'(p_aa_q) - FW'(p_bb_q) + FW'(kn2_q);
			end
			S_LD: begin
				negf_q <= neg_q > pos_q;
				num1_q <= f1_q;
				den1_q <= f3_q;
				num2_q <= (neg_q > pos_q) ? neg_q - pos_q : pos_q - neg_q;
				den2_q <= f4_q;
				q1_q   <= '0;
				q2_q   <= '0;
			end
			S_DV: begin
				if (it6_q == '0) begin
					sat1_q <= num1_q >= den1_q;
					sat2_q <= num2_q >= den2_q;
				end else begin
					if (t1 >= den1_q) begin
						num1_q <= t1 - den1_q;
						q1_q   <= {q1_q[13:0], 1'b1};
					end else begin
						num1_q <= t1;
						q1_q   <= {q1_q[13:0], 1'b0};
					end
					if (t2 >= den2_q) begin
						num2_q <= t2 - den2_q;
						q2_q   <= {q2_q[13:0], 1'b1};
					end else begin
						num2_q <= t2;
						q2_q   <= {q2_q[13:0], 1'b0};
					end
				end
			end
			S_MG: begin
				mag_q <= prod[31:15];
			end
			S_FD: begin
				tneg_q <= total_q < 0;
				dvd_q  <= (total_q < 0) ? sbwm_pkg::TW'(-total_q) : sbwm_pkg::TW'(total_q);
				rem_q  <= '0;
			end
			S_FDS: begin
				if (rem_n >= {1'b0, count_q}) begin
					rem_q <= rem_n - {1'b0, count_q};
					dvd_q <= {dvd_q[sbwm_pkg::TW-2:0], 1'b1};
				end else begin
					rem_q <= rem_n;
					dvd_q <= {dvd_q[sbwm_pkg::TW-2:0], 1'b0};
				end
			end
			S_FM: begin
				res_mean_q <= tneg_q ? -dvd_q[15:0] : dvd_q[15:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			k_q        <= '0;
			it6_q      <= '0;
			total_q    <= '0;
			count_q    <= '0;
			out_valid  <= 1'b0;
			out_mean   <= '0;
			out_count  <= '0;
		end else begin
			out_valid <= (state_q == S_EMIT) || (out_valid && !out_ready);
			if (restart) begin
				total_q <= '0;
				count_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (item.inv) begin
							total_q    <= '0;
							count_q    <= '0;
							state_q    <= S_EMIT;
						end else if (item.ok) begin
							state_q <= S_RD;
						end else if (item.last) begin
							state_q <= S_FD;
						end
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_UPD;
				S_UPD: begin
					k_q <= '0;
					if (it_q.fire && count_q < sbwm_pkg::COUNT_CAP) begin
						state_q <= S_SUM;
					end else if (it_q.last) begin
						state_q <= S_FD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SUM: begin
					if (k_q == win) begin
						state_q <= S_P1;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_LD;
				S_LD: begin
					it6_q   <= '0;
					state_q <= S_DV;
				end
				S_DV: begin
					if (it6_q == 6'd15) begin
						state_q <= S_MG;
					end else begin
						it6_q <= it6_q + 1'b1;
					end
				end
				S_MG: state_q <= S_AC;
				S_AC: begin
					total_q <= total_q + {{31{ssim[16]}}, ssim};
					count_q <= count_q + 1'b1;
					state_q <= it_q.last ? S_FD : S_IDLE;
				end
				S_FD: begin
					it6_q   <= '0;
					state_q <= (count_q == '0) ? S_FM : S_FDS;
				end
				S_FDS: begin
					if (it6_q == 6'(sbwm_pkg::TW - 1)) begin
						state_q <= S_FM;
					end else begin
						it6_q <= it6_q + 1'b1;
					end
				end
				S_FM: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						out_mean  <= (it_q.inv || count_q == '0) ? 16'd0 : res_mean_q;
						out_count <= count_q;
						total_q   <= '0;
						count_q   <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SUM |-> k_q <= win) else $error("window column index overran");
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sbwm_pkg::COUNT_CAP) else $error("window count above cap");
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DV |-> den1_q != '0 && den2_q != '0) else $error("zero denominator");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && !out_valid |=> out_valid) else $error("result word lost");
`endif

endmodule

// ----- sim/ssim_box_window_metric_checker.sv -----
// Checker for the SSIM box window unit: predicts frame results and compares them.
`timescale 1ns / 100ps

module ssim_box_window_metric_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	// a_red, a_green, a_blue, b_red, b_green, b_blue
	input  logic [47:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// ssim_mean, window_count, zero padding
	input  logic [39:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [15:0] mean;
		logic [20:0] count;
	} frame_result_t;

	localparam longint unsigned K1 = 426148;
	localparam longint unsigned K2 = 3835319;
	localparam int unsigned CAP = 1048576;

	frame_result_t expected_frames[$];

	int unsigned fw, fh, wsize, wstride;
	int unsigned row_pos, col_pos, win_count;
	longint signed ssim_sum;
	logic [31:0] luma_ring [0:sbwm_pkg::RING_DEPTH-1];
	longint unsigned col_a [0:sbwm_pkg::MAX_WIDTH-1];
	longint unsigned col_b [0:sbwm_pkg::MAX_WIDTH-1];
	longint unsigned col_aa [0:sbwm_pkg::MAX_WIDTH-1];
	longint unsigned col_bb [0:sbwm_pkg::MAX_WIDTH-1];
	longint unsigned col_ab [0:sbwm_pkg::MAX_WIDTH-1];

	assign pending = expected_frames.size();

	function automatic int unsigned luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int unsigned acc;
		acc = 19595 * r + 38470 * g + 7471 * b;
		return acc >> 8;
	endfunction

	function automatic int unsigned ratio_q15(longint unsigned num, longint unsigned den);
		int unsigned q;
		q = 0;
		if (num >= den)
			return 32768;
		for (int i = 0; i < 15; i++) begin
			num = num << 1;
			q = q << 1;
			if (num >= den) begin
				num = num - den;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic int signed window_score(longint unsigned n, longint unsigned sa,
			longint unsigned sb, longint unsigned saa, longint unsigned sbb,
			longint unsigned sab);
		longint unsigned nn, f1, f3, pos, neg, f4, mag;
		int unsigned r1, r2;
		bit negative;
		nn = n * n;
		f1 = 2 * sa * sb + K1 * nn;
		f3 = sa * sa + sb * sb + K1 * nn;
		pos = 2 * n * sab + K2 * nn;
		neg = 2 * sa * sb;
		f4 = n * (saa + sbb) - sa * sa - sb * sb + K2 * nn;
		r1 = ratio_q15(f1, f3);
		negative = neg > pos;
		r2 = negative ? ratio_q15(neg - pos, f4) : ratio_q15(pos - neg, f4);
		mag = (longint'(r1) * r2) >> 15;
		if (negative)
			return -int'(mag);
		return mag > 32767 ? 32767 : int'(mag);
	endfunction

	task automatic restart_frame();
		row_pos = 0;
		col_pos = 0;
		ssim_sum = 0;
		win_count = 0;
	endtask

	task automatic take_pixel(input logic [47:0] d);
		int unsigned x, y, la, lb, idx;
		longint unsigned oa, ob, sa, sb, saa, sbb, sab;
		longint unsigned mag;
		longint signed mean;
		bit ok;
		frame_result_t res;
		if (fw < 1 || fw > sbwm_pkg::MAX_WIDTH || fh < 1) begin
			restart_frame();
			res.mean = '0;
			res.count = '0;
			expected_frames.push_back(res);
			return;
		end
		if (col_pos >= fw || row_pos >= fh)
			restart_frame();
		x = col_pos;
		y = row_pos;
		la = luma(d[7:0], d[15:8], d[23:16]);
		lb = luma(d[31:24], d[39:32], d[47:40]);
		ok = wsize >= 2 && wsize <= sbwm_pkg::MAX_WINDOW && wstride >= 1 && wsize <= fw
			&& wsize <= fh;
		if (ok) begin
			idx = (y % wsize) * sbwm_pkg::MAX_WIDTH + x;
			if (y == 0) begin
				col_a[x] = la;
				col_b[x] = lb;
				col_aa[x] = longint'(la) * la;
				col_bb[x] = longint'(lb) * lb;
				col_ab[x] = longint'(la) * lb;
			end else begin
				if (y >= wsize) begin
					oa = luma_ring[idx][15:0];
					ob = luma_ring[idx][31:16];
					col_a[x] -= oa;
					col_b[x] -= ob;
					col_aa[x] -= oa * oa;
					col_bb[x] -= ob * ob;
					col_ab[x] -= oa * ob;
				end
				col_a[x] += la;
				col_b[x] += lb;
				col_aa[x] += longint'(la) * la;
				col_bb[x] += longint'(lb) * lb;
				col_ab[x] += longint'(la) * lb;
			end
			luma_ring[idx] = {lb[15:0], la[15:0]};
			if (y + 1 >= wsize && (y + 1 - wsize) % wstride == 0 &&
					x + 1 >= wsize && (x + 1 - wsize) % wstride == 0 && win_count < CAP) begin
				sa = 0; sb = 0; saa = 0; sbb = 0; sab = 0;
				for (int unsigned c = x + 1 - wsize; c <= x; c++) begin
					sa += col_a[c];
					sb += col_b[c];
					saa += col_aa[c];
					sbb += col_bb[c];
					sab += col_ab[c];
				end
				ssim_sum += window_score(wsize * wsize, sa, sb, saa, sbb, sab);
				win_count++;
			end
		end
		if (x + 1 < fw) begin
			col_pos = x + 1;
			return;
		end
		col_pos = 0;
		if (y + 1 < fh) begin
			row_pos = y + 1;
			return;
		end
		mean = 0;
		if (win_count != 0) begin
			mag = ssim_sum < 0 ? -ssim_sum : ssim_sum;
			mag = mag / win_count;
			mean = ssim_sum < 0 ? -longint'(mag) : longint'(mag);
		end
		res.mean = mean[15:0];
		res.count = win_count[20:0];
		expected_frames.push_back(res);
		restart_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_result_t exp_res;
		if (!arst_n) begin
			fw = 1024;
			fh = 1024;
			wsize = 8;
			wstride = 4;
			restart_frame();
			expected_frames.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (sbwm_pkg::cfg_idx_t'(cfg_index))
					sbwm_pkg::CFG_FRAME_WIDTH:   fw = cfg_wdata[10:0];
					sbwm_pkg::CFG_FRAME_HEIGHT:  fh = cfg_wdata[15:0];
					sbwm_pkg::CFG_WINDOW_SIZE:   wsize = cfg_wdata[4:0];
					sbwm_pkg::CFG_WINDOW_STRIDE: wstride = cfg_wdata[10:0];
				endcase
				restart_frame();
			end
			if (s_axis_tvalid && s_axis_tready)
				take_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_frames.size() == 0) begin
					$error("unexpected result word %h", m_axis_tdata);
					fail_count++;
				end else begin
					exp_res = expected_frames.pop_front();
					if (m_axis_tdata[15:0] !== exp_res.mean) begin
						$error("ssim_mean expected %0d got %0d", $signed(exp_res.mean),
							$signed(m_axis_tdata[15:0]));
						fail_count++;
					end
					if (m_axis_tdata[36:16] !== exp_res.count) begin
						$error("window_count expected %0d got %0d", exp_res.count,
							m_axis_tdata[36:16]);
						fail_count++;
					end
					if (m_axis_tdata[39:37] !== 3'b000) begin
						$error("padding expected 0 got %b", m_axis_tdata[39:37]);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ----- sim/ssim_box_window_metric_unit_test.sv -----
// Testbench top for the SSIM box window unit: stimulus, idling and verdict.
`timescale 1ns / 100ps

module ssim_box_window_metric_unit_test;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// a_red, a_green, a_blue, b_red, b_green, b_blue
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// ssim_mean, window_count, zero padding
	logic [39:0] m_axis_tdata;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	int fail_count;
	int pending;
	int sent_words;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	bit hold_req;

	ssim_box_window_metric_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	ssim_box_window_metric_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver side: random stalls, plus one long hold-off on request
	initial m_axis_tready = 1'b0;
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	task automatic send_word(input logic [47:0] d);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = d;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent_words++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input sbwm_pkg::cfg_idx_t idx, input int unsigned val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val[15:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic setup(input int unsigned w, input int unsigned h, input int unsigned sz,
			input int unsigned st);
		drain();
		write_reg(sbwm_pkg::CFG_FRAME_WIDTH, w);
		write_reg(sbwm_pkg::CFG_FRAME_HEIGHT, h);
		write_reg(sbwm_pkg::CFG_WINDOW_SIZE, sz);
		write_reg(sbwm_pkg::CFG_WINDOW_STRIDE, st);
	endtask

	function automatic logic [47:0] rand_word();
		return 48'({$urandom, $urandom});
	endfunction

	task automatic send_random(input int n);
		for (int i = 0; i < n; i++)
			send_word(rand_word());
	endtask

	initial begin
		int unsigned w, h, sz, st, frames, pick;
		logic [47:0] extremes [0:8];
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = sbwm_pkg::CFG_FRAME_WIDTH;
		cfg_wdata = '0;
		sent_words = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		extremes[0] = '0;
		extremes[1] = '1;
		extremes[2] = 48'h000000_FFFFFF;
		extremes[3] = 48'hFFFFFF_000000;
		extremes[4] = 48'hAAAAAA_555555;
		extremes[5] = 48'h555555_AAAAAA;
		extremes[6] = 48'h0000FF_0000FF;
		extremes[7] = 48'h00FF00_FF0000;
		extremes[8] = '1;

		// directed: uniform, opposite and bit-pattern pixels in a tiny frame
		setup(3, 3, 2, 1);
		for (int i = 0; i < 9; i++)
			send_word(extremes[i]);
		// invalid geometry: every word closes its own frame
		setup(0, 3, 2, 1);
		send_word('1);
		send_word('0);
		setup(1025, 3, 2, 1);
		send_word('1);
		setup(2, 0, 2, 1);
		send_word('1);
		// window too small, stride zero, window wider than frame
		setup(2, 2, 1, 1);
		send_random(4);
		setup(2, 2, 2, 0);
		send_random(4);
		setup(2, 3, 3, 1);
		send_random(6);

		// long receiver hold-off while words keep coming
		setup(0, 1, 2, 1);
		hold_req = 1'b1;
		send_random(40);

		// wide frame, stride beyond the width
		setup(320, 2, 2, 1023);
		send_random(640);
		// largest window
		setup(16, 16, 16, 2047);
		send_random(256);
		// tall frame abandoned partway
		setup(1, 65535, 2, 1);
		send_random(20);

		for (int phase = 0; sent_words < 1700; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			pick = $urandom_range(9);
			sz = $urandom_range(6, 2);
			w = $urandom_range(12, sz);
			h = $urandom_range(8, sz);
			st = ($urandom_range(9) == 0) ? 1024 : $urandom_range(4, 1);
			if (pick == 0)
				sz = ($urandom_range(1) == 0) ? $urandom_range(1) : $urandom_range(31, 17);
			else if (pick == 1)
				st = 0;
			else if (pick == 2)
				w = ($urandom_range(1) == 0) ? 0 : $urandom_range(2047, 1025);
			else if (pick == 3)
				h = 0;
			setup(w, h, sz, st);
			if (pick == 2 || pick == 3)
				send_random($urandom_range(6, 1));
			else begin
				frames = $urandom_range(3, 1);
				send_random(frames * w * h);
				if ($urandom_range(4) == 0)
					send_random($urandom_range(w * h - 1, 1));
			end
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
